// ----- hdl/rfc_pkg.sv -----
`timescale 1ns / 1ps
package rfc_pkg;

  localparam int FRAC_BITS = 16;

  localparam int BOUND_W   = 26;
  localparam int RES_W     = 42;
  localparam int TOL_W     = 25;
  localparam int ITER_W    = 8;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 2;

  localparam int MAG_W     = 25;              // |x| <= 2^24
  localparam int SQ_W      = 49;              // x^2
  localparam int PROD_W    = 2 * MAG_W;       // shared multiplier output
  localparam int CUBE_W    = 41;
  localparam int DIFF_W    = 26;              // |b - a|
  localparam int DEN_W     = 43;              // |f(b) - f(a)|
  localparam int REM_W     = 45;
  localparam int DIV_CNT_W = 5;

  localparam logic signed [BOUND_W-1:0] BOUND_MAX = 26'sd16777216;
  localparam logic signed [RES_W-1:0]   TWO_FX    = RES_W'(64'sd2 <<< FRAC_BITS);

  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER  = 2'd1;

  typedef enum logic [STATUS_W-1:0] {
    ST_CONVERGED = 2'd0,
    ST_LIMIT     = 2'd1,
    ST_NO_SIGN   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    TGT_A = 2'd0,
    TGT_B = 2'd1,
    TGT_C = 2'd2
  } tgt_e;

  typedef struct packed {
    logic load_in;
    logic cube_sq;
    logic cube_lo;
    logic cube_hi;
    logic cube_fin;
    tgt_e tgt;
    logic x_from_b;
    logic div_init;
    logic div_step;
    logic calc_c;
    logic update;
    logic set_result;
    logic set_nosign;
  } cmd_t;

  typedef struct packed {
    logic no_sign;
    logic div_last;
    logic stop;
    logic out_busy;
  } sts_t;

endpackage

// ----- hdl/rfc_in_if.sv -----
`timescale 1ns / 1ps
interface rfc_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [rfc_pkg::BOUND_W-1:0] lower_bound;
  logic signed [rfc_pkg::BOUND_W-1:0] upper_bound;

  modport source (output valid, output lower_bound, output upper_bound, input ready);
  modport sink   (input valid, input lower_bound, input upper_bound, output ready);
endinterface

// ----- hdl/rfc_out_if.sv -----
`timescale 1ns / 1ps
interface rfc_out_if;
  logic                                valid;
  logic                                ready;
  logic        [rfc_pkg::STATUS_W-1:0] status;
  logic signed [rfc_pkg::BOUND_W-1:0]  root_estimate;
  logic signed [rfc_pkg::RES_W-1:0]    residual;
  logic        [rfc_pkg::ITER_W-1:0]   iterations_done;

  modport source (output valid, output status, output root_estimate, output residual,
                  output iterations_done, input ready);
  modport sink   (input valid, input status, input root_estimate, input residual,
                  input iterations_done, output ready);
endinterface

// ----- hdl/rfc_cfg_if.sv -----
`timescale 1ns / 1ps
interface rfc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [rfc_pkg::CFG_IDX_W-1:0]    index;
  logic [rfc_pkg::TOL_W-1:0]        data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/rfc_ctrl.sv -----
`timescale 1ns / 1ps
module rfc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_fire_i,
  input  rfc_pkg::sts_t sts_i,
  output rfc_pkg::cmd_t cmd_o,
  output logic          in_ready_o
);
  import rfc_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_SQ       = 11'b000_0000_0010,
    S_LO       = 11'b000_0000_0100,
    S_HI       = 11'b000_0000_1000,
    S_FIN      = 11'b000_0001_0000,
    S_CHECK    = 11'b000_0010_0000,
    S_DIV_INIT = 11'b000_0100_0000,
    S_DIV_STEP = 11'b000_1000_0000,
    S_CALC_C   = 11'b001_0000_0000,
    S_UPDATE   = 11'b010_0000_0000,
    S_DONE     = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;
  tgt_e   tgt_q, tgt_d;
  logic   nosign_q, nosign_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      tgt_q    <= TGT_A;
      nosign_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      tgt_q    <= tgt_d;
      nosign_q <= nosign_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d  = state_q;
    tgt_d    = tgt_q;
    nosign_d = nosign_q;
    cmd_o    = '0;
    cmd_o.tgt = tgt_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire_i) begin
          cmd_o.load_in = 1'b1;
          tgt_d   = TGT_A;
          state_d = S_SQ;
        end
      end
      S_SQ: begin
        cmd_o.cube_sq = 1'b1;
        state_d = S_LO;
      end
      S_LO: begin
        cmd_o.cube_lo = 1'b1;
        state_d = S_HI;
      end
      S_HI: begin
        cmd_o.cube_hi = 1'b1;
        state_d = S_FIN;
      end
      S_FIN: begin
        cmd_o.cube_fin = 1'b1;
        case (tgt_q)
          TGT_A: begin
            cmd_o.x_from_b = 1'b1;
            tgt_d   = TGT_B;
            state_d = S_SQ;
          end
          TGT_B:   state_d = S_CHECK;
          default: state_d = S_UPDATE;
        endcase
      end
      S_CHECK: begin
        nosign_d = sts_i.no_sign;
        state_d  = sts_i.no_sign ? S_DONE : S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd_o.div_init = 1'b1;
        state_d = S_DIV_STEP;
      end
      S_DIV_STEP: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = S_CALC_C;
      end
      S_CALC_C: begin
        cmd_o.calc_c = 1'b1;
        tgt_d   = TGT_C;
        state_d = S_SQ;
      end
      S_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d = sts_i.stop ? S_DONE : S_DIV_INIT;
      end
      S_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.set_result = !nosign_q;
          cmd_o.set_nosign = nosign_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule

// ----- hdl/rfc_dp.sv -----
`timescale 1ns / 1ps
module rfc_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic signed [rfc_pkg::BOUND_W-1:0]  lower_bound_i,
  input  logic signed [rfc_pkg::BOUND_W-1:0]  upper_bound_i,
  input  logic        [rfc_pkg::TOL_W-1:0]    tolerance_i,
  input  logic        [rfc_pkg::ITER_W-1:0]   max_iterations_i,
  input  rfc_pkg::cmd_t                       cmd_i,
  output rfc_pkg::sts_t                       sts_o,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic        [rfc_pkg::STATUS_W-1:0] status_o,
  output logic signed [rfc_pkg::BOUND_W-1:0]  root_estimate_o,
  output logic signed [rfc_pkg::RES_W-1:0]    residual_o,
  output logic        [rfc_pkg::ITER_W-1:0]   iterations_done_o
);
  import rfc_pkg::*;

  logic signed [BOUND_W-1:0] a_q, b_q, c_q, x_q;
  logic signed [RES_W-1:0]   fa_q, fb_q, fc_q;
  logic [SQ_W-1:0]           x2_q;
  logic [PROD_W-1:0]         p0_q, p1_q;
  logic [ITER_W-1:0]         it_q;
  logic [DIFF_W-1:0]         d_q, quo_q;
  logic [RES_W-1:0]          n_q;
  logic [DEN_W-1:0]          den_q;
  logic [REM_W-1:0]          rem_q;
  logic [DIV_CNT_W-1:0]      cnt_q;
  logic                      neg_q, den_zero_q;

  logic                      out_valid_q;
  status_e                   out_status_q;
  logic signed [BOUND_W-1:0] out_root_q;
  logic signed [RES_W-1:0]   out_res_q;
  logic [ITER_W-1:0]         out_iter_q;

  function automatic logic signed [BOUND_W-1:0] clamp(input logic signed [BOUND_W-1:0] v);
    logic signed [BOUND_W-1:0] r;
    r = v;
    if (v > BOUND_MAX) r = BOUND_MAX;
    if (v < -BOUND_MAX) r = -BOUND_MAX;
    return r;
  endfunction

  // Cube unit: one shared multiplier, |x|^2 then x^2 * |x| in two partial products.
  logic signed [BOUND_W-1:0]   x_neg;
  logic [MAG_W-1:0]            ax, mul_a;
  logic [PROD_W-1:0]           prod;
  logic [SQ_W+MAG_W-1:0]       full;
  logic [CUBE_W-1:0]           cube;
  logic signed [RES_W-1:0]     cube_s, f_v;

  assign x_neg = -x_q;
  assign ax    = x_q[BOUND_W-1] ? x_neg[MAG_W-1:0] : x_q[MAG_W-1:0];

  always_comb begin
    if (cmd_i.cube_sq)      mul_a = ax;
    else if (cmd_i.cube_lo) mul_a = x2_q[MAG_W-1:0];
    else                    mul_a = MAG_W'(x2_q[SQ_W-1:MAG_W]);
  end

  assign prod   = PROD_W'(mul_a) * PROD_W'(ax);
  assign full   = {p1_q[SQ_W-1:0], {MAG_W{1'b0}}} + (SQ_W + MAG_W)'(p0_q);
  assign cube   = full[2*FRAC_BITS +: CUBE_W];
  assign cube_s = x_q[BOUND_W-1] ? -$signed({1'b0, cube}) : $signed({1'b0, cube});
  assign f_v    = cube_s - RES_W'(x_q) - TWO_FX;

  // Division setup.
  logic signed [BOUND_W:0]   d_v, d_neg;
  logic signed [DEN_W-1:0]   den_v, den_neg;
  logic signed [RES_W-1:0]   fb_neg;

  assign d_v     = (BOUND_W + 1)'(b_q) - (BOUND_W + 1)'(a_q);
  assign d_neg   = -d_v;
  assign den_v   = DEN_W'(fb_q) - DEN_W'(fa_q);
  assign den_neg = -den_v;
  assign fb_neg  = -fb_q;

  // One quotient bit per cycle; the partial remainder stays below three divisors.
  logic [REM_W-1:0]  rem2, den1, den2;
  logic [1:0]        qinc;
  logic [REM_W-1:0]  rem_nx;

  assign rem2 = {rem_q[REM_W-2:0], 1'b0} + (d_q[DIFF_W-1] ? REM_W'(n_q) : '0);
  assign den1 = REM_W'(den_q);
  assign den2 = REM_W'({den_q, 1'b0});

  always_comb begin
    if (rem2 >= den2) begin
      rem_nx = rem2 - den2;
      qinc   = 2'd2;
    end else if (rem2 >= den1) begin
      rem_nx = rem2 - den1;
      qinc   = 2'd1;
    end else begin
      rem_nx = rem2;
      qinc   = 2'd0;
    end
  end

  logic signed [BOUND_W:0] b_ext, q_ext, c_v;
  assign b_ext = (BOUND_W + 1)'(b_q);
  assign q_ext = $signed({1'b0, quo_q});
  always_comb begin
    if (den_zero_q)  c_v = b_ext;
    else if (neg_q)  c_v = b_ext + q_ext;
    else             c_v = b_ext - q_ext;
  end

  // Stop test and bracketing test.
  logic signed [RES_W-1:0] fc_neg;
  logic [RES_W-1:0]        err;
  logic                    conv;
  logic [ITER_W-1:0]       limit;
  logic [ITER_W:0]         it_inc;
  logic                    fa_pos, fa_neg, fb_pos, fb_neg_s, flip;

  assign fc_neg = -fc_q;
  assign err    = fc_q[RES_W-1] ? fc_neg : fc_q;
  assign conv   = err <= RES_W'(tolerance_i);
  assign limit  = (max_iterations_i == '0) ? ITER_W'(1) : max_iterations_i;
  assign it_inc = (ITER_W + 1)'(it_q) + (ITER_W + 1)'(1);

  assign fa_neg   = fa_q[RES_W-1];
  assign fa_pos   = !fa_q[RES_W-1] && (fa_q != '0);
  assign fb_neg_s = fb_q[RES_W-1];
  assign fb_pos   = !fb_q[RES_W-1] && (fb_q != '0);
  assign flip     = (fc_q != '0) && (fa_q != '0) && (fc_q[RES_W-1] != fa_q[RES_W-1]);

  assign sts_o.no_sign  = !((fa_pos && fb_neg_s) || (fa_neg && fb_pos));
  assign sts_o.div_last = (cnt_q == '0);
  assign sts_o.stop     = conv || (it_inc >= (ITER_W + 1)'(limit));
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      a_q  <= clamp(lower_bound_i);
      b_q  <= clamp(upper_bound_i);
      x_q  <= clamp(lower_bound_i);
      it_q <= '0;
    end
    if (cmd_i.cube_sq) x2_q <= prod[SQ_W-1:0];
    if (cmd_i.cube_lo) p0_q <= prod;
    if (cmd_i.cube_hi) p1_q <= prod;
    if (cmd_i.cube_fin) begin
      case (cmd_i.tgt)
        TGT_A:   fa_q <= f_v;
        TGT_B:   fb_q <= f_v;
        TGT_C:   fc_q <= f_v;
        default: fc_q <= f_v;
      endcase
    end
    if (cmd_i.x_from_b) x_q <= b_q;
    if (cmd_i.div_init) begin
      d_q        <= d_v[BOUND_W] ? d_neg[DIFF_W-1:0] : d_v[DIFF_W-1:0];
      den_q      <= den_v[DEN_W-1] ? den_neg : den_v;
      n_q        <= fb_q[RES_W-1] ? fb_neg : fb_q;
      neg_q      <= fb_q[RES_W-1] ^ d_v[BOUND_W] ^ den_v[DEN_W-1];
      den_zero_q <= (den_v == '0);
      rem_q      <= '0;
      quo_q      <= '0;
      cnt_q      <= DIV_CNT_W'(DIFF_W - 1);
    end
    if (cmd_i.div_step) begin
      d_q   <= {d_q[DIFF_W-2:0], 1'b0};
      rem_q <= rem_nx;
      quo_q <= {quo_q[DIFF_W-2:0], 1'b0} + DIFF_W'(qinc);
      cnt_q <= cnt_q - DIV_CNT_W'(1);
    end
    if (cmd_i.calc_c) begin
      c_q <= c_v[BOUND_W-1:0];
      x_q <= c_v[BOUND_W-1:0];
    end
    if (cmd_i.update) begin
      if (flip) begin
        b_q  <= c_q;
        fb_q <= fc_q;
      end else begin
        a_q  <= c_q;
        fa_q <= fc_q;
      end
      it_q <= it_inc[ITER_W-1:0];
    end
    if (cmd_i.set_result) begin
      out_status_q <= conv ? ST_CONVERGED : ST_LIMIT;
      out_root_q   <= c_q;
      out_res_q    <= fc_q;
      out_iter_q   <= it_q;
    end
    if (cmd_i.set_nosign) begin
      out_status_q <= ST_NO_SIGN;
      out_root_q   <= '0;
      out_res_q    <= '0;
      out_iter_q   <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.set_result || cmd_i.set_nosign) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign root_estimate_o   = out_root_q;
  assign residual_o        = out_res_q;
  assign iterations_done_o = out_iter_q;
endmodule

// ----- hdl/regula_falsi_cubic_root_core.sv -----
// Channel  | Direction | Carries
// req_i    | in        | lower_bound, upper_bound (signed Q10.16)
// rsp_o    | out       | status, root_estimate, residual, iterations_done
// cfg_i    | in        | index (0 tolerance, 1 max_iterations), data
//
// A request is accepted, both end points are evaluated and the bracket is tested; then
// each false-position step runs the division setup, the bit-serial quotient, the cube on
// the shared 25x25 multiplier and the update, and the result is posted at the end.
// Reset restores tolerance 66 and max_iterations 150 and leaves the block idle.
// A finished result waits in the output register while the next request is taken;
// a new result is held back only while the previous one is still waiting.
`timescale 1ns / 1ps
module regula_falsi_cubic_root_core (
  input logic        clk_i,
  input logic        rst_ni,
  rfc_in_if.sink     req_i,
  rfc_out_if.source  rsp_o,
  rfc_cfg_if.sink    cfg_i
);
  import rfc_pkg::*;

  logic [TOL_W-1:0]  tol_q;
  logic [ITER_W-1:0] max_iter_q;
  cmd_t              cmd;
  sts_t              sts;
  logic              in_ready;
  logic              in_fire;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q      <= TOL_W'(66);
      max_iter_q <= ITER_W'(150);
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_TOLERANCE: tol_q      <= cfg_i.data;
        CFG_MAX_ITER:  max_iter_q <= cfg_i.data[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  assign req_i.ready = in_ready;
  assign in_fire     = req_i.valid && in_ready;

  rfc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_ready_o (in_ready)
  );

  rfc_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .lower_bound_i     (req_i.lower_bound),
    .upper_bound_i     (req_i.upper_bound),
    .tolerance_i       (tol_q),
    .max_iterations_i  (max_iter_q),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_ready_i       (rsp_o.ready),
    .out_valid_o       (rsp_o.valid),
    .status_o          (rsp_o.status),
    .root_estimate_o   (rsp_o.root_estimate),
    .residual_o        (rsp_o.residual),
    .iterations_done_o (rsp_o.iterations_done)
  );

  // The block works on one request at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("request accepted while a previous one was in progress");

  a_nosign_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.status == ST_NO_SIGN |->
      rsp_o.root_estimate == '0 && rsp_o.residual == '0 && rsp_o.iterations_done == '0)
    else $error("no-sign-change result carries nonzero fields");

  a_steps_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.status != ST_NO_SIGN |-> rsp_o.iterations_done != '0)
    else $error("bracketed result reports zero iterations");
endmodule
